[rtl/c8core_pkg.sv]
// Package for the CHIP-8 instruction core: constants and shared types.
package c8core_pkg;

    localparam int MemorySize = 4096;
    localparam int StackDepth = 16;
    localparam logic [11:0] StartReset = 12'd512;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_READ = 2'd1;
    localparam logic [1:0] REQ_EXEC = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_PC_RANGE  = 3'd1;
    localparam logic [2:0] ST_UNDERFLOW = 3'd2;
    localparam logic [2:0] ST_OVERFLOW  = 3'd3;
    localparam logic [2:0] ST_UNKNOWN   = 3'd4;
    localparam logic [2:0] ST_HALTED    = 3'd5;

    // One request as it sits in the queue between front and back.
    typedef struct packed {
        logic [1:0]  req_type;
        logic [11:0] mem_address;
        logic [7:0]  mem_data;
        logic [7:0]  random_byte;
    } req_t;

endpackage

[rtl/chip8_instruction_core.sv]
// The back end works on one request at a time; a two-entry queue takes new transfers
// meanwhile. A load writes memory, a no-op only returns a result, a read waits on the
// registered RAM, and an execute fetches both opcode bytes and decodes them (not when
// halted or pc is out of range). BCD and register dump then write memory byte by byte,
// and register load steps through address, wait and data states for each register.
// Reset clears registers, stack, timers and halt; pc loads 512; memory is not cleared.
module chip8_instruction_core #(
    parameter int STACK_DEPTH = c8core_pkg::StackDepth,
    parameter int MEMORY_SIZE = c8core_pkg::MemorySize
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [11:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [11:0] mem_address,
    input  logic [7:0]  mem_data,
    input  logic [7:0]  random_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic [11:0] program_counter,
    output logic [2:0]  status,
    output logic        beep
);

    logic             q_full, q_push, q_pop, q_empty;
    c8core_pkg::req_t q_data, q_head;

    // Front end.
    c8core_front u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .mem_address (mem_address),
        .mem_data    (mem_data),
        .random_byte (random_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_data)
    );

    // Queue between the two halves.
    c8core_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    // Back end.
    c8core_exec #(.STACK_DEPTH(STACK_DEPTH), .MEMORY_SIZE(MEMORY_SIZE)) u_exec (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .q_empty         (q_empty),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .read_data       (read_data),
        .program_counter (program_counter),
        .status          (status),
        .beep            (beep)
    );

endmodule

[rtl/c8core_ram.sv]
// Generic single-port RAM with registered read.
module c8core_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read on the one port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/c8core_queue.sv]
// Two-entry request queue between the front and the back.
module c8core_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  c8core_pkg::req_t   push_data,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output c8core_pkg::req_t   head
);

    c8core_pkg::req_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/c8core_front.sv]
// Front end: accepts input transfers and pushes them into the queue.
module c8core_front (
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       req_type,
    input  logic [11:0]      mem_address,
    input  logic [7:0]       mem_data,
    input  logic [7:0]       random_byte,
    input  logic             q_full,
    output logic             q_push,
    output c8core_pkg::req_t q_data
);

    // A transfer is taken whenever the queue has room.
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // The request fields go straight into the queue entry.
    always_comb
    begin
        q_data.req_type    = req_type;
        q_data.mem_address = mem_address;
        q_data.mem_data    = mem_data;
        q_data.random_byte = random_byte;
    end

endmodule

[rtl/c8core_exec.sv]
// Back end: sequencer that carries out one request over several cycles.
module c8core_exec #(
    parameter int STACK_DEPTH = c8core_pkg::StackDepth,
    parameter int MEMORY_SIZE = c8core_pkg::MemorySize
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [11:0]      cfg_data,
    input  logic             q_empty,
    input  c8core_pkg::req_t q_head,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       read_data,
    output logic [11:0]      program_counter,
    output logic [2:0]       status,
    output logic             beep
);

    typedef enum logic [3:0] {
        S_IDLE, S_RD_WAIT, S_FETCH_HI, S_FETCH_LO, S_DECODE, S_BCD, S_DUMP,
        S_LOAD_ADDR, S_LOAD_WAIT, S_LOAD_DATA, S_DONE, S_OUT
    } state_t;

    localparam int SW = $clog2(STACK_DEPTH);

    state_t      state_reg;
    logic [11:0] start_reg;
    logic [7:0]  v_reg [16];
    logic [11:0] stack_reg [STACK_DEPTH];
    logic [4:0]  level_reg;
    logic [11:0] pc_reg, index_reg;
    logic [7:0]  delay_reg, sound_reg;
    logic        halted_reg;
    logic [15:0] op_reg;
    logic [7:0]  rand_reg;
    logic [4:0]  step_reg;
    logic [7:0]  rd_reg;
    logic [2:0]  st_reg;
    logic        beep_reg;
    logic [11:0] pc_new_reg;

    // Memory port.
    logic        m_we;
    logic [11:0] m_addr;
    logic [7:0]  m_wdata, m_rdata;

    c8core_ram #(.WIDTH(8), .DEPTH(MEMORY_SIZE)) u_mem (
        .clk   (clk),
        .we    (m_we),
        .addr  (m_addr),
        .wdata (m_wdata),
        .rdata (m_rdata)
    );

    logic [3:0] x, y, n;
    logic [7:0] nn, vx, vy;
    logic [3:0] step4;
    assign x  = op_reg[11:8];
    assign y  = op_reg[7:4];
    assign n  = op_reg[3:0];
    assign nn = op_reg[7:0];
    assign vx = v_reg[x];
    assign vy = v_reg[y];
    assign step4 = step_reg[3:0];

    // BCD digits of Vx.
    logic [7:0] hund, tens, ones, rem1;
    always_comb
    begin
        hund = (vx >= 8'd200) ? 8'd2 : ((vx >= 8'd100) ? 8'd1 : 8'd0);
        rem1 = vx - 8'(hund * 8'd100);
        tens = 8'((16'(rem1) * 16'd205) >> 11);
        ones = rem1 - 8'(tens * 8'd10);
    end

    // Memory address and write selection.
    always_comb
    begin
        m_we    = 1'b0;
        m_addr  = pc_reg;
        m_wdata = 8'd0;
        case (state_reg)
            S_IDLE:
            begin
                // An execute request starts the opcode fetch at pc.
                m_addr  = (q_head.req_type == c8core_pkg::REQ_EXEC) ? pc_reg
                                                                     : q_head.mem_address;
                m_we    = !q_empty && (q_head.req_type == c8core_pkg::REQ_LOAD);
                m_wdata = q_head.mem_data;
            end
            S_FETCH_HI: m_addr = pc_reg + 12'd1;
            S_BCD:
            begin
                m_we   = 1'b1;
                m_addr = index_reg + 12'(step_reg);
                case (step_reg[1:0])
                    2'd0:    m_wdata = hund;
                    2'd1:    m_wdata = tens;
                    default: m_wdata = ones;
                endcase
            end
            S_DUMP:
            begin
                m_we    = 1'b1;
                m_addr  = index_reg + 12'(step_reg);
                m_wdata = v_reg[step4];
            end
            S_LOAD_ADDR, S_LOAD_WAIT: m_addr = index_reg + 12'(step_reg);
            default:     m_addr = pc_reg;
        endcase
    end

    assign q_pop = (state_reg == S_IDLE) && !q_empty;
    assign out_valid       = (state_reg == S_OUT);
    assign read_data       = rd_reg;
    assign program_counter = pc_reg;
    assign status          = st_reg;
    assign beep            = beep_reg;

    // Decode result computed combinationally from the fetched opcode.
    logic [2:0]  d_st;
    logic [11:0] d_next, adv;
    logic        d_wx, d_wf, d_push, d_pop, d_bcd, d_dump, d_load;
    logic [7:0]  d_vx, d_vf;
    logic [8:0]  sum9;
    always_comb
    begin
        adv    = pc_reg + 12'd2;
        d_st   = c8core_pkg::ST_OK;
        d_next = adv;
        d_wx   = 1'b0;
        d_wf   = 1'b0;
        d_vx   = 8'd0;
        d_vf   = 8'd0;
        d_push = 1'b0;
        d_pop  = 1'b0;
        d_bcd  = 1'b0;
        d_dump = 1'b0;
        d_load = 1'b0;
        sum9   = {1'b0, vx} + {1'b0, vy};
        case (op_reg[15:12])
            4'h0:
            begin
                if (op_reg == 16'h00EE)
                begin
                    if (level_reg == 5'd0)
                    begin
                        d_st = c8core_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        d_pop  = 1'b1;
                        d_next = stack_reg[SW'(level_reg - 5'd1)];
                    end
                end
            end
            4'h1: d_next = op_reg[11:0];
            4'h2:
            begin
                if (32'(level_reg) + 32'd1 >= 32'(STACK_DEPTH))
                begin
                    d_st = c8core_pkg::ST_OVERFLOW;
                end
                else
                begin
                    d_push = 1'b1;
                    d_next = op_reg[11:0];
                end
            end
            4'h3: if (vx == nn) d_next = adv + 12'd2;
            4'h4: if (vx != nn) d_next = adv + 12'd2;
            4'h5:
            begin
                if (n != 4'd0) d_st = c8core_pkg::ST_UNKNOWN;
                else if (vx == vy) d_next = adv + 12'd2;
            end
            4'h6:
            begin
                d_wx = 1'b1;
                d_vx = nn;
            end
            4'h7:
            begin
                d_wx = 1'b1;
                d_vx = vx + nn;
            end
            4'h8:
            begin
                d_wx = 1'b1;
                case (n)
                    4'h0: d_vx = vy;
                    4'h1: d_vx = vx | vy;
                    4'h2: d_vx = vx & vy;
                    4'h3: d_vx = vx ^ vy;
                    4'h4:
                    begin
                        d_vx = sum9[7:0];
                        d_wf = 1'b1;
                        d_vf = {7'd0, sum9[8]};
                    end
                    4'h5:
                    begin
                        d_vx = vx - vy;
                        d_wf = 1'b1;
                        d_vf = {7'd0, vy <= vx};
                    end
                    4'h6:
                    begin
                        d_vx = {1'b0, vx[7:1]};
                        d_wf = 1'b1;
                        d_vf = {7'd0, vx[0]};
                    end
                    4'h7:
                    begin
                        d_vx = vy - vx;
                        d_wf = 1'b1;
                        d_vf = {7'd0, vx <= vy};
                    end
                    4'hE:
                    begin
                        d_vx = {vx[6:0], 1'b0};
                        d_wf = 1'b1;
                        d_vf = {7'd0, vx[7]};
                    end
                    default:
                    begin
                        d_wx = 1'b0;
                        d_st = c8core_pkg::ST_UNKNOWN;
                    end
                endcase
            end
            4'h9:
            begin
                if (n != 4'd0) d_st = c8core_pkg::ST_UNKNOWN;
                else if (vx != vy) d_next = adv + 12'd2;
            end
            4'hA: ;
            4'hB: d_next = op_reg[11:0] + {4'd0, v_reg[0]};
            4'hC:
            begin
                d_wx = 1'b1;
                d_vx = rand_reg & nn;
            end
            4'hD: ;
            4'hE:
            begin
                if (nn != 8'h9E && nn != 8'hA1) d_st = c8core_pkg::ST_UNKNOWN;
            end
            default:
            begin
                case (nn)
                    8'h07:
                    begin
                        d_wx = 1'b1;
                        d_vx = delay_reg;
                    end
                    8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29: ;
                    8'h33: d_bcd = 1'b1;
                    8'h55: d_dump = 1'b1;
                    8'h65: d_load = 1'b1;
                    default: d_st = c8core_pkg::ST_UNKNOWN;
                endcase
            end
        endcase
    end

    // Sequencer and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            start_reg  <= c8core_pkg::StartReset;
            for (int i = 0; i < 16; i++) v_reg[i] <= 8'd0;
            for (int i = 0; i < STACK_DEPTH; i++) stack_reg[i] <= 12'd0;
            level_reg  <= 5'd0;
            pc_reg     <= c8core_pkg::StartReset;
            index_reg  <= 12'd0;
            delay_reg  <= 8'd0;
            sound_reg  <= 8'd0;
            halted_reg <= 1'b0;
            op_reg     <= 16'd0;
            rand_reg   <= 8'd0;
            step_reg   <= 5'd0;
            rd_reg     <= 8'd0;
            st_reg     <= c8core_pkg::ST_OK;
            beep_reg   <= 1'b0;
            pc_new_reg <= 12'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                start_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        rd_reg   <= 8'd0;
                        st_reg   <= c8core_pkg::ST_OK;
                        beep_reg <= 1'b0;
                        rand_reg <= q_head.random_byte;
                        case (q_head.req_type)
                            c8core_pkg::REQ_READ: state_reg <= S_RD_WAIT;
                            c8core_pkg::REQ_EXEC:
                            begin
                                if (halted_reg)
                                begin
                                    st_reg    <= c8core_pkg::ST_HALTED;
                                    state_reg <= S_OUT;
                                end
                                else if (32'(pc_reg) + 32'd1 >= 32'(MEMORY_SIZE))
                                begin
                                    st_reg     <= c8core_pkg::ST_PC_RANGE;
                                    halted_reg <= 1'b1;
                                    state_reg  <= S_OUT;
                                end
                                else
                                begin
                                    state_reg <= S_FETCH_HI;
                                end
                            end
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end
                S_RD_WAIT:
                begin
                    rd_reg    <= m_rdata;
                    state_reg <= S_OUT;
                end
                S_FETCH_HI:
                begin
                    op_reg[15:8] <= m_rdata;
                    state_reg    <= S_FETCH_LO;
                end
                S_FETCH_LO:
                begin
                    op_reg[7:0] <= m_rdata;
                    state_reg   <= S_DECODE;
                end
                S_DECODE:
                begin
                    step_reg <= 5'd0;
                    if (d_st != c8core_pkg::ST_OK)
                    begin
                        st_reg     <= d_st;
                        halted_reg <= 1'b1;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        pc_new_reg <= d_next;
                        // When X is VF the result replaces the flag.
                        if (d_wf && !(d_wx && x == 4'hF)) v_reg[15] <= d_vf;
                        if (d_wx) v_reg[x] <= d_vx;
                        if (d_push)
                        begin
                            stack_reg[SW'(level_reg)] <= adv;
                            level_reg <= level_reg + 5'd1;
                        end
                        if (d_pop) level_reg <= level_reg - 5'd1;
                        if (op_reg[15:12] == 4'hA) index_reg <= op_reg[11:0];
                        if (op_reg[15:12] == 4'hF)
                        begin
                            if (nn == 8'h15) delay_reg <= vx;
                            if (nn == 8'h18) sound_reg <= vx;
                            if (nn == 8'h1E) index_reg <= index_reg + {4'd0, vx};
                        end
                        if (d_bcd) state_reg <= S_BCD;
                        else if (d_dump) state_reg <= S_DUMP;
                        else if (d_load) state_reg <= S_LOAD_ADDR;
                        else state_reg <= S_DONE;
                    end
                end
                S_BCD:
                begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd2) state_reg <= S_DONE;
                end
                S_DUMP:
                begin
                    step_reg <= step_reg + 5'd1;
                    if (step4 == x) state_reg <= S_DONE;
                end
                S_LOAD_ADDR: state_reg <= S_LOAD_WAIT;
                S_LOAD_WAIT: state_reg <= S_LOAD_DATA;
                S_LOAD_DATA:
                begin
                    v_reg[step4] <= m_rdata;
                    step_reg     <= step_reg + 5'd1;
                    if (step4 == x) state_reg <= S_DONE;
                    else state_reg <= S_LOAD_ADDR;
                end
                S_DONE:
                begin
                    pc_reg <= pc_new_reg;
                    if (delay_reg != 8'd0) delay_reg <= delay_reg - 8'd1;
                    if (sound_reg != 8'd0) sound_reg <= sound_reg - 8'd1;
                    beep_reg  <= (sound_reg == 8'd2);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[tb/sv/chip8_instruction_core_tb.sv]
// Self-checking testbench for the CHIP-8 instruction core, with its own cycle predictor.
`timescale 1ns / 100ps

module chip8_instruction_core_tb;

    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam int ItemTarget = 550;

    // Architectural state of the core as the predictor sees it.
    typedef struct {
        logic [7:0]  mem [c8core_pkg::MemorySize];
        bit          wr [c8core_pkg::MemorySize];
        logic [7:0]  v [16];
        logic [11:0] stk [16];
        int          lvl;
        logic [11:0] pc;
        logic [11:0] idx;
        logic [7:0]  dt;
        logic [7:0]  snd;
        bit          halted;
    } core_state_t;

    typedef struct packed {
        logic [7:0]  rd;
        logic [11:0] pc;
        logic [2:0]  st;
        logic        bp;
    } core_result_t;

    typedef struct packed {
        logic [1:0]  rq;
        logic [11:0] a;
        logic [7:0]  d;
        logic [7:0]  r;
        bit          typed;
        logic [7:0]  rd;
        logic [11:0] pc;
        logic [2:0]  st;
        logic        bp;
    } opening_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [11:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  req_type;
    logic [11:0] mem_address;
    logic [7:0]  mem_data;
    logic [7:0]  random_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  read_data;
    logic [11:0] program_counter;
    logic [2:0]  status;
    logic        beep;

    core_state_t  core_model;
    core_result_t pending_results[$];
    int           mismatches;
    int           items_sent;
    int           cycles_run;
    int           beeps_seen;
    int           burst_left;
    int           stall_pct;
    int           stall_cnt;

    // Hand-written opening sequence: byte access, flag against result, beep, extremes.
    opening_row_t opening_rows [24] = '{
        '{c8core_pkg::REQ_LOAD, 12'h200, 8'h60, 8'h00, 1'b1, 8'h00, 12'h200,
          c8core_pkg::ST_OK, 1'b0},
        '{c8core_pkg::REQ_LOAD, 12'h201, 8'hFF, 8'hFF, 1'b1, 8'h00, 12'h200,
          c8core_pkg::ST_OK, 1'b0},
        '{c8core_pkg::REQ_READ, 12'h201, 8'h00, 8'h00, 1'b1, 8'hFF, 12'h200,
          c8core_pkg::ST_OK, 1'b0},
        '{c8core_pkg::REQ_EXEC, 12'h000, 8'h00, 8'h00, 1'b1, 8'h00, 12'h202,
          c8core_pkg::ST_OK, 1'b0},
        '{c8core_pkg::REQ_LOAD, 12'h202, 8'h8F, 8'h00, 1'b0, 8'h00, 12'h000,
          c8core_pkg::ST_OK, 1'b0},
        '{c8core_pkg::REQ_LOAD, 12'h203, 8'h04, 8'h00, 1'b0, 8'h00, 12'h000,
          c8core_pkg::ST_OK, 1'b0},
        '{c8core_pkg::REQ_EXEC, 12'h000, 8'h00, 8'h00, 1'b0, 8'h00, 12'h000,
          c8core_pkg::ST_OK, 1'b0},
        '{c8core_pkg::REQ_LOAD, 12'h204, 8'h8F, 8'h00, 1'b0, 8'h00, 12'h000,
          c8core_pkg::ST_OK, 1'b0},
        '{c8core_pkg::REQ_LOAD, 12'h205, 8'h0E, 8'h00, 1'b0, 8'h00, 12'h000,
          c8core_pkg::ST_OK, 1'b0},
        '{c8core_pkg::REQ_EXEC, 12'h000, 8'h00, 8'h00, 1'b0, 8'h00, 12'h000,
          c8core_pkg::ST_OK, 1'b0},
        '{c8core_pkg::REQ_LOAD, 12'h206, 8'h60, 8'h00, 1'b0, 8'h00, 12'h000,
          c8core_pkg::ST_OK, 1'b0},
        '{c8core_pkg::REQ_LOAD, 12'h207, 8'h02, 8'h00, 1'b0, 8'h00, 12'h000,
          c8core_pkg::ST_OK, 1'b0},
        '{c8core_pkg::REQ_EXEC, 12'h000, 8'h00, 8'h00, 1'b0, 8'h00, 12'h000,
          c8core_pkg::ST_OK, 1'b0},
        '{c8core_pkg::REQ_LOAD, 12'h208, 8'hF0, 8'h00, 1'b0, 8'h00, 12'h000,
          c8core_pkg::ST_OK, 1'b0},
        '{c8core_pkg::REQ_LOAD, 12'h209, 8'h18, 8'h00, 1'b0, 8'h00, 12'h000,
          c8core_pkg::ST_OK, 1'b0},
        '{c8core_pkg::REQ_EXEC, 12'h000, 8'h00, 8'h00, 1'b0, 8'h00, 12'h000,
          c8core_pkg::ST_OK, 1'b0},
        '{c8core_pkg::REQ_LOAD, 12'hFFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 12'h000,
          c8core_pkg::ST_OK, 1'b0},
        '{c8core_pkg::REQ_READ, 12'hFFF, 8'h00, 8'h00, 1'b0, 8'h00, 12'h000,
          c8core_pkg::ST_OK, 1'b0},
        '{c8core_pkg::REQ_LOAD, 12'h000, 8'h00, 8'h00, 1'b0, 8'h00, 12'h000,
          c8core_pkg::ST_OK, 1'b0},
        '{c8core_pkg::REQ_READ, 12'h000, 8'h00, 8'h00, 1'b0, 8'h00, 12'h000,
          c8core_pkg::ST_OK, 1'b0},
        '{REQ_NONE, 12'hFFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 12'h000,
          c8core_pkg::ST_OK, 1'b0},
        '{c8core_pkg::REQ_LOAD, 12'h20A, 8'hC1, 8'h00, 1'b0, 8'h00, 12'h000,
          c8core_pkg::ST_OK, 1'b0},
        '{c8core_pkg::REQ_LOAD, 12'h20B, 8'hF0, 8'h00, 1'b0, 8'h00, 12'h000,
          c8core_pkg::ST_OK, 1'b0},
        '{c8core_pkg::REQ_EXEC, 12'h000, 8'h00, 8'hAA, 1'b0, 8'h00, 12'h000,
          c8core_pkg::ST_OK, 1'b0}
    };

    chip8_instruction_core i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .mem_address     (mem_address),
        .mem_data        (mem_data),
        .random_byte     (random_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .read_data       (read_data),
        .program_counter (program_counter),
        .status          (status),
        .beep            (beep)
    );

    // Clock generation.
    always #2 clk = ~clk;

    // Stores one byte into the predicted memory and marks it as written.
    function automatic void store_byte(ref core_state_t s, input logic [11:0] a,
                                       input logic [7:0] val);
        s.mem[a] = val;
        s.wr[a]  = 1'b1;
    endfunction

    // Executes one machine cycle on the predicted state and returns its status.
    function automatic logic [2:0] run_cycle(ref core_state_t s, input logic [7:0] rnd);
        logic [15:0] op;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [7:0]  nn;
        logic [7:0]  vx;
        logic [7:0]  vy;
        logic [7:0]  res;
        logic [7:0]  flag;
        logic [8:0]  sum;
        logic [11:0] nnn;
        logic [11:0] nxt;
        bit          has_flag;
        int          i;
        if (int'(s.pc) + 1 >= c8core_pkg::MemorySize)
            return c8core_pkg::ST_PC_RANGE;
        op  = {s.mem[s.pc], s.mem[s.pc + 12'd1]};
        nxt = s.pc + 12'd2;
        x   = op[11:8];
        y   = op[7:4];
        nn  = op[7:0];
        nnn = op[11:0];
        vx  = s.v[x];
        vy  = s.v[y];
        case (op[15:12])
            4'h0:
            begin
                if (op == 16'h00EE)
                begin
                    if (s.lvl == 0)
                        return c8core_pkg::ST_UNDERFLOW;
                    s.lvl--;
                    nxt = s.stk[s.lvl];
                end
            end
            4'h1: nxt = nnn;
            4'h2:
            begin
                if (s.lvl + 1 >= c8core_pkg::StackDepth)
                    return c8core_pkg::ST_OVERFLOW;
                s.stk[s.lvl] = nxt;
                s.lvl++;
                nxt = nnn;
            end
            4'h3: if (vx == nn) nxt = nxt + 12'd2;
            4'h4: if (vx != nn) nxt = nxt + 12'd2;
            4'h5:
            begin
                if (op[3:0] != 4'h0)
                    return c8core_pkg::ST_UNKNOWN;
                if (vx == vy) nxt = nxt + 12'd2;
            end
            4'h6: s.v[x] = nn;
            4'h7: s.v[x] = vx + nn;
            4'h8:
            begin
                has_flag = 1'b1;
                flag     = 8'd0;
                case (op[3:0])
                    4'h0: begin res = vy;      has_flag = 1'b0; end
                    4'h1: begin res = vx | vy; has_flag = 1'b0; end
                    4'h2: begin res = vx & vy; has_flag = 1'b0; end
                    4'h3: begin res = vx ^ vy; has_flag = 1'b0; end
                    4'h4:
                    begin
                        sum  = {1'b0, vx} + {1'b0, vy};
                        res  = sum[7:0];
                        flag = {7'd0, sum[8]};
                    end
                    4'h5: begin res = vx - vy; flag = (vy > vx) ? 8'd0 : 8'd1; end
                    4'h6: begin res = vx >> 1; flag = {7'd0, vx[0]}; end
                    4'h7: begin res = vy - vx; flag = (vx > vy) ? 8'd0 : 8'd1; end
                    4'hE: begin res = vx << 1; flag = {7'd0, vx[7]}; end
                    default: return c8core_pkg::ST_UNKNOWN;
                endcase
                // The flag goes in first, so the result wins when X is VF.
                if (has_flag)
                    s.v[15] = flag;
                s.v[x] = res;
            end
            4'h9:
            begin
                if (op[3:0] != 4'h0)
                    return c8core_pkg::ST_UNKNOWN;
                if (vx != vy) nxt = nxt + 12'd2;
            end
            4'hA: s.idx = nnn;
            4'hB: nxt = nnn + {4'd0, s.v[0]};
            4'hC: s.v[x] = rnd & nn;
            4'hD: ;
            4'hE:
            begin
                if (nn != 8'h9E && nn != 8'hA1)
                    return c8core_pkg::ST_UNKNOWN;
            end
            default:
            begin
                case (nn)
                    8'h07: s.v[x] = s.dt;
                    8'h0A: ;
                    8'h15: s.dt = vx;
                    8'h18: s.snd = vx;
                    8'h1E: s.idx = s.idx + {4'd0, vx};
                    8'h29: ;
                    8'h33:
                    begin
                        store_byte(s, s.idx, vx / 8'd100);
                        store_byte(s, s.idx + 12'd1, (vx / 8'd10) % 8'd10);
                        store_byte(s, s.idx + 12'd2, vx % 8'd10);
                    end
                    8'h55:
                        for (i = 0; i <= int'(x); i++)
                            store_byte(s, s.idx + 12'(i), s.v[i]);
                    8'h65:
                        for (i = 0; i <= int'(x); i++)
                            s.v[i] = s.mem[s.idx + 12'(i)];
                    default: return c8core_pkg::ST_UNKNOWN;
                endcase
            end
        endcase
        s.pc = nxt;
        if (s.dt != 8'd0) s.dt--;
        if (s.snd != 8'd0) s.snd--;
        return c8core_pkg::ST_OK;
    endfunction

    // Applies one request to the predicted state and returns the result it causes.
    function automatic core_result_t predict_request(ref core_state_t s, input logic [1:0] rq,
                                                     input logic [11:0] a,
                                                     input logic [7:0] d,
                                                     input logic [7:0] rnd);
        core_result_t r;
        r = '0;
        r.st = c8core_pkg::ST_OK;
        case (rq)
            c8core_pkg::REQ_LOAD: store_byte(s, a, d);
            c8core_pkg::REQ_READ: r.rd = s.mem[a];
            c8core_pkg::REQ_EXEC:
            begin
                if (s.halted)
                    r.st = c8core_pkg::ST_HALTED;
                else
                begin
                    r.st = run_cycle(s, rnd);
                    if (r.st != c8core_pkg::ST_OK)
                        s.halted = 1'b1;
                    else
                        r.bp = (s.snd == 8'd1);
                end
            end
            default: ;
        endcase
        r.pc = s.pc;
        return r;
    endfunction

    // Picks a random opcode, weighted over every instruction group.
    function automatic logic [15:0] random_opcode();
        logic [3:0]  x;
        logic [3:0]  y;
        logic [7:0]  nn;
        logic [7:0]  fsel [9];
        x  = 4'($urandom_range(0, 15));
        y  = 4'($urandom_range(0, 15));
        nn = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 4)) : 8'($urandom);
        fsel = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65};
        case ($urandom_range(0, 17))
            0:  return ($urandom_range(0, 1) == 0) ? 16'h00E0 : {4'h0, 12'($urandom)};
            1:  return 16'h00EE;
            2:  return {4'h1, 12'($urandom)};
            3:  return {4'h2, 12'($urandom)};
            4:  return {4'h3, x, nn};
            5:  return {4'h4, x, nn};
            6:  return {4'h5, x, y, 4'h0};
            7:  return {4'h6, x, nn};
            8:  return {4'h7, x, nn};
            9:
            begin
                if ($urandom_range(0, 8) == 8)
                    return {4'h8, x, y, 4'hE};
                return {4'h8, x, y, 4'($urandom_range(0, 7))};
            end
            10: return {4'h9, x, y, 4'h0};
            11: return {4'hA, 12'($urandom)};
            12: return {4'hB, 12'($urandom)};
            13: return {4'hC, x, nn};
            14: return {4'hD, x, y, 4'($urandom)};
            15: return {4'hE, x, ($urandom_range(0, 1) == 0) ? 8'h9E : 8'hA1};
            default: return {4'hF, x, fsel[$urandom_range(0, 8)]};
        endcase
    endfunction

    // Prints one mismatch line and counts it.
    task automatic report(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // Offers one transfer to the core, with burst gaps, and records what it must return.
    task automatic send(input logic [1:0] rq, input logic [11:0] a, input logic [7:0] d,
                        input logic [7:0] rnd, input bit typed = 1'b0,
                        input core_result_t want = '0);
        core_result_t pred;
        int           gap;
        pred = predict_request(core_model, rq, a, d, rnd);
        pending_results.push_back(typed ? want : pred);
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_valid    <= 1'b1;
        req_type    <= rq;
        mem_address <= a;
        mem_data    <= d;
        random_byte <= rnd;
        do
            @(posedge clk);
        while (in_stall);
        burst_left--;
        items_sent++;
    endtask

    // Places an opcode at the current pc, fills any unwritten bytes a register load
    // would touch, and executes it.
    task automatic place_and_run(input logic [15:0] op);
        logic [11:0] a;
        int          i;
        send(c8core_pkg::REQ_LOAD, core_model.pc, op[15:8], 8'($urandom));
        send(c8core_pkg::REQ_LOAD, core_model.pc + 12'd1, op[7:0], 8'($urandom));
        if (op[15:12] == 4'hF && op[7:0] == 8'h65)
            for (i = 0; i <= int'(op[11:8]); i++)
            begin
                a = core_model.idx + 12'(i);
                if (!core_model.wr[a])
                    send(c8core_pkg::REQ_LOAD, a, 8'($urandom), 8'($urandom));
            end
        send(c8core_pkg::REQ_EXEC, 12'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Draws up to 40 opcodes for one that runs cleanly and leaves pc fetchable (else 1200), then runs it.
    task automatic run_clean_opcode();
        core_state_t trial;
        logic [15:0] op;
        int          tries;
        for (tries = 0; tries < 40; tries++)
        begin
            op = random_opcode();
            trial = core_model;
            trial.mem[trial.pc] = op[15:8];
            trial.mem[trial.pc + 12'd1] = op[7:0];
            if (run_cycle(trial, 8'h00) == c8core_pkg::ST_OK && trial.pc != 12'hFFF)
                break;
        end
        if (tries == 40)
            op = 16'h1200;
        place_and_run(op);
    endtask

    // Lets the core drain, then waits a little so nothing is still in flight.
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Writes the start address while the core is idle.
    task automatic write_start(input logic [11:0] val);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver stall pattern: the stall rate is redrawn each time stall_cnt wraps, sometimes to none.
    always @(posedge clk)
    begin
        cycles_run++;
        stall_cnt++;
        if (stall_cnt == 64)
        begin
            stall_cnt = 0;
            case ($urandom_range(0, 3))
                0, 1:    stall_pct = 0;
                2:       stall_pct = 30;
                default: stall_pct = 75;
            endcase
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Result checking against the oldest pending expectation.
    always @(posedge clk)
    begin
        core_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report("unexpected transfer", program_counter, 0);
            else
            begin
                want = pending_results.pop_front();
                if (read_data !== want.rd)
                    report("read_data", read_data, want.rd);
                if (program_counter !== want.pc)
                    report("program_counter", program_counter, want.pc);
                if (status !== want.st)
                    report("status", status, want.st);
                if (beep !== want.bp)
                    report("beep", beep, want.bp);
                if (want.bp)
                    beeps_seen++;
            end
        end
    end

    // Main stimulus.
    initial
    begin
        core_result_t want;
        opening_row_t row;
        int           i;
        int           pick;
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_data    = 12'd0;
        in_valid    = 1'b0;
        req_type    = c8core_pkg::REQ_LOAD;
        mem_address = 12'd0;
        mem_data    = 8'd0;
        random_byte = 8'd0;
        out_stall   = 1'b0;
        mismatches  = 0;
        items_sent  = 0;
        cycles_run  = 0;
        beeps_seen  = 0;
        burst_left  = 0;
        stall_pct   = 0;
        stall_cnt   = 0;

        // The predicted state matches the reset state of the core.
        for (i = 0; i < c8core_pkg::MemorySize; i++)
        begin
            core_model.mem[i] = 8'd0;
            core_model.wr[i]  = 1'b0;
        end
        for (i = 0; i < 16; i++)
        begin
            core_model.v[i]   = 8'd0;
            core_model.stk[i] = 12'd0;
        end
        core_model.lvl    = 0;
        core_model.pc     = c8core_pkg::StartReset;
        core_model.idx    = 12'd0;
        core_model.dt     = 8'd0;
        core_model.snd    = 8'd0;
        core_model.halted = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The start address register does not feed pc, so pc must not follow it.
        write_start(12'hFFF);

        // Opening sequence.
        for (i = 0; i < 24; i++)
        begin
            row  = opening_rows[i];
            want = '{row.rd, row.pc, row.st, row.bp};
            send(row.rq, row.a, row.d, row.r, row.typed, want);
        end
        write_start(12'h000);

        // Random part: mostly clean programs, with loads, reads and unused requests mixed in.
        while (items_sent < ItemTarget)
        begin
            if (items_sent >= ItemTarget / 2 && cfg_data == 12'h000)
                write_start(12'($urandom_range(1, 4094)));
            pick = $urandom_range(0, 99);
            if (pick < 72)
                run_clean_opcode();
            else if (pick < 84)
            begin
                // Only written bytes are read back.
                if (!core_model.wr[core_model.pc])
                    send(c8core_pkg::REQ_LOAD, core_model.pc, 8'($urandom), 8'($urandom));
                send(c8core_pkg::REQ_READ, core_model.pc, 8'($urandom), 8'($urandom));
            end
            else if (pick < 94)
                send(c8core_pkg::REQ_LOAD, 12'($urandom), 8'($urandom), 8'($urandom));
            else
                send(REQ_NONE, 12'($urandom), 8'($urandom), 8'($urandom));
        end

        // Closing part: drive the core into one error, chosen at random, then check
        // that it stays halted while memory access keeps working.
        case ($urandom_range(0, 3))
            0: place_and_run(16'hE000);
            1:
            begin
                place_and_run(16'h1FFF);
                send(c8core_pkg::REQ_EXEC, 12'd0, 8'd0, 8'($urandom));
            end
            2:
            begin
                while (!core_model.halted && core_model.lvl > 0)
                    place_and_run(16'h00EE);
                if (!core_model.halted)
                    place_and_run(16'h00EE);
            end
            default:
                while (!core_model.halted)
                    place_and_run({4'h2, 12'($urandom_range(0, 4093))});
        endcase
        send(c8core_pkg::REQ_EXEC, 12'd0, 8'd0, 8'($urandom));
        send(c8core_pkg::REQ_LOAD, 12'h123, 8'h5A, 8'($urandom));
        send(c8core_pkg::REQ_READ, 12'h123, 8'h00, 8'($urandom));
        send(c8core_pkg::REQ_EXEC, 12'hFFF, 8'hFF, 8'hFF);
        write_start(c8core_pkg::StartReset);

        repeat (60) @(posedge clk);
        $display("Sent %0d transfers over %0d cycles; %0d beeps seen, stack depth at the end %0d.",
                 items_sent, cycles_run, beeps_seen, core_model.lvl);
        $display("Covered byte load and read, every opcode group, and one halting error.");
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #20000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
